// ===== sv/integer_alu_with_power_defines.svh =====
// Assertion macros used by the RTL controller.
`ifndef INTEGER_ALU_WITH_POWER_DEFINES_SVH
`define INTEGER_ALU_WITH_POWER_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition that holds at every clock edge out of reset.
`define IALU_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent.
`define IALU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define IALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IALU_ASSERT(label, cond, msg)
`define IALU_ASSERT_IMPL(label, ante, cons, msg)
`define IALU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/ialu_pkg.sv =====
`default_nettype none

package ialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CMD_W      = 4;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [CMD_W-1:0] OP_ADD = 4'd0;
    localparam logic [CMD_W-1:0] OP_SUB = 4'd1;
    localparam logic [CMD_W-1:0] OP_MUL = 4'd2;
    localparam logic [CMD_W-1:0] OP_DIV = 4'd3;
    localparam logic [CMD_W-1:0] OP_MOD = 4'd4;
    localparam logic [CMD_W-1:0] OP_POW = 4'd5;
    localparam logic [CMD_W-1:0] OP_AND = 4'd6;
    localparam logic [CMD_W-1:0] OP_XOR = 4'd7;
    localparam logic [CMD_W-1:0] OP_OR  = 4'd8;
    localparam logic [CMD_W-1:0] OP_NEG = 4'd9;
    localparam logic [CMD_W-1:0] OP_ABS = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic iterative;
    } ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/ialu_datapath.sv =====
`default_nettype none

module ialu_datapath
    import ialu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    input  wire ctl_cmd_t              cmd,
    output ctl_sts_t                   sts,
    output logic [DATA_WIDTH-1:0]      result,
    output logic                       undefined
);

    localparam int W = DATA_WIDTH;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    logic [CMD_W-1:0] op_reg;
    logic             neg_a_reg;
    logic             neg_b_reg;
    logic             zero_b_reg;
    logic [W-1:0]     base_reg, base_next;
    logic [W-1:0]     aux_reg, aux_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     shf_reg, shf_next;
    logic [W-1:0]     res_reg, res_next;
    logic             undef_reg, undef_next;

    logic [W-1:0]     prod_acc;
    logic [W-1:0]     prod_sq;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             qbit;
    logic             is_div_op;

    assign prod_acc = acc_reg * base_reg;
    assign prod_sq  = base_reg * base_reg;

    // Shift-subtract step on the magnitudes: remainder in acc, quotient builds in shf
    assign rem_sh = {acc_reg, shf_reg[W-1]};
    assign diff   = rem_sh - {1'b0, aux_reg};
    assign qbit   = ~diff[W];

    assign is_div_op     = (command == OP_DIV) || (command == OP_MOD);
    assign sts.iterative = (op_reg == OP_DIV) || (op_reg == OP_MOD) || (op_reg == OP_POW);

    always_comb
    begin
        base_next = base_reg;
        aux_next  = aux_reg;
        acc_next  = acc_reg;
        shf_next  = shf_reg;
        if (cmd.load)
        begin
            base_next = operand_a;
            aux_next  = is_div_op ? mag(operand_b) : operand_b;
            shf_next  = mag(operand_a);
            if (command == OP_POW)
                acc_next = W'(1);
            else if (command == OP_MUL)
                acc_next = operand_b;
            else
                acc_next = '0;
        end
        else if (cmd.step)
        begin
            if (op_reg == OP_POW)
            begin
                if (aux_reg[0])
                    acc_next = prod_acc;
                base_next = prod_sq;
                aux_next  = aux_reg >> 1;
            end
            else
            begin
                acc_next = qbit ? diff[W-1:0] : rem_sh[W-1:0];
                shf_next = {shf_reg[W-2:0], qbit};
            end
        end
    end

    always_comb
    begin
        undef_next = 1'b0;
        unique case (op_reg)
            OP_ADD: res_next = base_reg + aux_reg;
            OP_SUB: res_next = base_reg - aux_reg;
            OP_MUL: res_next = prod_acc;
            OP_DIV:
            begin
                undef_next = zero_b_reg;
                if (zero_b_reg)
                    res_next = '0;
                else
                    res_next = (neg_a_reg ^ neg_b_reg) ? (~shf_reg + W'(1)) : shf_reg;
            end
            OP_MOD:
            begin
                undef_next = zero_b_reg;
                if (zero_b_reg)
                    res_next = '0;
                else
                    res_next = neg_a_reg ? (~acc_reg + W'(1)) : acc_reg;
            end
            OP_POW: res_next = neg_b_reg ? '0 : acc_reg;
            OP_AND: res_next = base_reg & aux_reg;
            OP_XOR: res_next = base_reg ^ aux_reg;
            OP_OR:  res_next = base_reg | aux_reg;
            OP_NEG: res_next = ~base_reg + W'(1);
            OP_ABS: res_next = mag(base_reg);
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= '0;
            neg_a_reg  <= 1'b0;
            neg_b_reg  <= 1'b0;
            zero_b_reg <= 1'b0;
            base_reg   <= '0;
            aux_reg    <= '0;
            acc_reg    <= '0;
            shf_reg    <= '0;
            res_reg    <= '0;
            undef_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg     <= command;
                neg_a_reg  <= operand_a[W-1];
                neg_b_reg  <= operand_b[W-1];
                zero_b_reg <= (operand_b == '0);
            end
            base_reg <= base_next;
            aux_reg  <= aux_next;
            acc_reg  <= acc_next;
            shf_reg  <= shf_next;
            if (cmd.finish)
            begin
                res_reg   <= res_next;
                undef_reg <= undef_next;
            end
        end
    end

    assign result    = res_reg;
    assign undefined = undef_reg;

endmodule

`default_nettype wire

// ===== sv/ialu_ctrl.sv =====
`default_nettype none

`include "integer_alu_with_power_defines.svh"

module ialu_ctrl
    import ialu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!sts.iterative)
                    state_next = S_FINISH;
                else
                begin
                    cmd.step = 1'b1;
                    if (cnt_reg == '0)
                        state_next = S_FINISH;
                    else
                        cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `IALU_ASSERT_NEXT(a_accept_runs, in_valid && in_ready, state_reg == S_RUN,
        "accepted transfer did not start the run")
    `IALU_ASSERT_IMPL(a_no_overwrite, cmd.finish, !out_valid_reg || out_ready,
        "result register overwritten while a transfer is pending")
    `IALU_ASSERT_NEXT(a_last_step, state_reg == S_RUN && sts.iterative && cnt_reg == '0,
        state_reg == S_FINISH, "iteration did not end after the last step")
    `IALU_ASSERT(a_step_in_run, !cmd.step || (state_reg == S_RUN && sts.iterative),
        "step issued outside an iterative run")

endmodule

`default_nettype wire

// ===== sv/integer_alu_with_power.sv =====
`default_nettype none

// Signed integer ALU on 32-bit two's-complement operands: add, sub, mul, div, mod, pow,
// and, xor, or, negate and abs, all wrapping. Div truncates toward zero and mod takes the
// dividend's sign; a zero divisor gives result 0 with the undefined flag set, and a
// negative exponent gives 0. One item is in work at a time. Add, sub, mul, the logic ops,
// negate, abs and unused commands pass through accept, one datapath pass and the write of
// the output register; div, mod and pow pass through a capture, 32 iterations of the
// shared step (shift-subtract for div/mod, one square and one conditional multiply for
// pow) and the write of the output register. The result and its valid flag are registered
// together at that write. A finished result waits in the output register while the next
// item is accepted; the write of the next result stalls until that transfer happens.
module integer_alu_with_power
    import ialu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [2*DATA_WIDTH-1:0] s_axis_tdata,  // operand_a, operand_b
    input  wire logic [CMD_W-1:0]       s_axis_tuser,  // command
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [DATA_WIDTH-1:0]       m_axis_tdata,  // result
    output logic                        m_axis_tuser   // undefined
);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    ialu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (ctl_sts),
        .cmd       (ctl_cmd)
    );

    ialu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (s_axis_tuser),
        .operand_a (s_axis_tdata[DATA_WIDTH-1:0]),
        .operand_b (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .cmd       (ctl_cmd),
        .sts       (ctl_sts),
        .result    (m_axis_tdata),
        .undefined (m_axis_tuser)
    );

endmodule

`default_nettype wire
